/* hw/rtl/esrs_pkg.sv */
// Package for the SPI angle-sensor read sequencer.
// Holds phase and event codes, frame constants, result struct and the
// command-frame helper. No dependencies.
package esrs_pkg;

    localparam int unsigned FRAME_W = 16;
    localparam int unsigned DATA_W  = 14;
    localparam int unsigned ERR_W   = 5;
    localparam int unsigned PAR_BIT  = 15;
    localparam int unsigned FLAG_BIT = 14;

    localparam logic [DATA_W-1:0] ADDR_ANGLE = 14'h3FFE;
    localparam logic [DATA_W-1:0] ADDR_DIAG  = 14'h3FFC;
    localparam logic [DATA_W-1:0] ADDR_ERRFL = 14'h0001;
    localparam logic [DATA_W-1:0] ADDR_NOP   = 14'h0000;

    // error flag bit positions
    localparam int unsigned ERR_ANY   = 0;
    localparam int unsigned ERR_BUS   = 1;
    localparam int unsigned ERR_PAR   = 2;
    localparam int unsigned ERR_ADDR  = 3;
    localparam int unsigned ERR_FRAME = 4;

    typedef enum logic [1:0] {
        EV_START_ANGLE = 2'd0,
        EV_START_DIAG  = 2'd1,
        EV_FRAME       = 2'd2,
        EV_BUS_FAULT   = 2'd3
    } esrs_event_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_CMD    = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_ERRCMD = 5'b01000,
        PH_ERRFL  = 5'b10000
    } esrs_phase_t;

    // first member sits in the highest bits: accepted ends up at bit 0
    typedef struct packed {
        logic [ERR_W-1:0]   error_flags;
        logic [DATA_W-1:0]  read_data;
        logic               done_res;
        logic [FRAME_W-1:0] tx_frame;
        logic               tx_send;
        logic               accepted;
    } esrs_result_t;

    localparam int unsigned RESULT_W = $bits(esrs_result_t);
    localparam int unsigned M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // read command: address, read flag, even parity over the whole frame
    function automatic logic [FRAME_W-1:0] read_cmd(input logic [DATA_W-1:0] addr);
        logic [FRAME_W-2:0] f;
        f = {1'b1, addr};
        return {^f, f};
    endfunction

endpackage

/* hw/rtl/esrs_step.sv */
// Next-state and result logic for one event of the read sequencer.
// Purely combinational; depends on esrs_pkg.
module esrs_step
    import esrs_pkg::*;
(
    input  esrs_event_t         func,
    input  logic [FRAME_W-1:0]  rx_frame,
    input  esrs_phase_t         phase,
    input  logic [ERR_W-1:0]    err,
    input  logic [DATA_W-1:0]   data,
    output esrs_phase_t         phase_next,
    output logic [ERR_W-1:0]    err_next,
    output logic [DATA_W-1:0]   data_next,
    output esrs_result_t        result
);

    esrs_phase_t ph;
    logic        bad;

    // unreachable codes behave as idle
    always_comb
    begin
        unique case (phase)
            PH_IDLE, PH_CMD, PH_DATA, PH_ERRCMD, PH_ERRFL: ph = phase;
            default:                                       ph = PH_IDLE;
        endcase
    end

    assign bad = (err != '0) || (^rx_frame) || rx_frame[FLAG_BIT];

    always_comb
    begin
        logic             acc;
        logic             send;
        logic [FRAME_W-1:0] frame;
        logic             done;
        acc        = 1'b0;
        send       = 1'b0;
        frame      = '0;
        done       = 1'b0;
        phase_next = ph;
        err_next   = err;
        data_next  = data;
        unique case (func)
            EV_START_ANGLE, EV_START_DIAG:
            begin
                if (ph == PH_IDLE)
                begin
                    acc        = 1'b1;
                    err_next   = '0;
                    phase_next = PH_CMD;
                    send       = 1'b1;
                    frame      = read_cmd((func == EV_START_ANGLE) ? ADDR_ANGLE : ADDR_DIAG);
                end
            end
            EV_BUS_FAULT:
            begin
                err_next[ERR_ANY] = 1'b1;
                err_next[ERR_BUS] = 1'b1;
                phase_next        = PH_IDLE;
                done              = 1'b1;
            end
            default:
            begin
                if (ph != PH_IDLE)
                begin
                    if (bad)
                    begin
                        err_next[ERR_ANY] = 1'b1;
                        if (ph == PH_CMD)
                        begin
                            send       = 1'b1;
                            frame      = read_cmd(ADDR_ERRFL);
                            phase_next = PH_ERRCMD;
                        end
                        else if (ph == PH_ERRCMD || ph == PH_DATA)
                        begin
                            send       = 1'b1;
                            frame      = read_cmd(ADDR_NOP);
                            phase_next = PH_ERRFL;
                        end
                        else
                        begin
                            // ERRFL answer: flags decoded regardless of its parity
                            if (rx_frame[2]) err_next[ERR_PAR]   = 1'b1;
                            if (rx_frame[1]) err_next[ERR_ADDR]  = 1'b1;
                            if (rx_frame[0]) err_next[ERR_FRAME] = 1'b1;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    else if (ph == PH_CMD)
                    begin
                        send       = 1'b1;
                        frame      = read_cmd(ADDR_ERRFL);
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        data_next  = rx_frame[DATA_W-1:0];
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
        endcase
        result.accepted    = acc;
        result.tx_send     = send;
        result.tx_frame    = frame;
        result.done_res    = done;
        result.read_data   = data_next;
        result.error_flags = err_next;
    end

endmodule

/* hw/rtl/encoder_spi_read_sequencer_top.sv */
// Each input transfer is captured in the input register and its result in the result register.
// Throughput: one event per cycle while m_tready drains the result; an empty input register still fills while it waits.
// The only loop is the phase/error/data state update, computed combinationally and registered once per fired event.
// Reset (rst_n, async, active low): phase idle, errors and data cleared, both stages empty.
// Top level of the SPI read sequencer; depends on esrs_pkg and esrs_step.
module encoder_spi_read_sequencer_top
    import esrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] rx_frame
    input  logic [1:0]           s_tuser,   // [1:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] accepted, [1] tx_send, [17:2] tx_frame, [18] done_res,
    // [32:19] read_data, [37:33] error_flags, [39:38] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic               in_vld_reg;
    esrs_event_t        func_reg;
    logic [FRAME_W-1:0] rx_reg;

    esrs_phase_t        phase_reg, phase_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [DATA_W-1:0]  data_reg, data_next;

    logic               out_vld_reg;
    esrs_result_t       out_reg, step_res;

    logic               advance;
    logic               fire;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    esrs_step u_step (
        .func       (func_reg),
        .rx_frame   (rx_reg),
        .phase      (phase_reg),
        .err        (err_reg),
        .data       (data_reg),
        .phase_next (phase_next),
        .err_next   (err_next),
        .data_next  (data_next),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            err_reg     <= '0;
            data_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (advance)
                out_vld_reg <= in_vld_reg;
            if (fire)
            begin
                phase_reg <= phase_next;
                err_reg   <= err_next;
                data_reg  <= data_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            func_reg <= esrs_event_t'(s_tuser);
            rx_reg   <= s_tdata;
        end
        if (fire)
            out_reg <= step_res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_res.done_res |=> phase_reg == PH_IDLE)
        else $error("phase not idle after sequence end");

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.accepted |-> out_reg.tx_send && out_reg.error_flags == '0)
        else $error("accepted start without command or with stale errors");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty result stage");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(err_reg) && $stable(data_reg))
        else $error("state changed without an event");
`endif

endmodule
